/* design/psf_pkg.sv */
// Shared constants, types and lookup functions for the printf formatter.
package psf_pkg;

    localparam int CNT_W      = 31;
    localparam int NUM_DIGITS = 10;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [31:0]      RECIP_10  = 32'hCCCC_CCCD;

    localparam logic [1:0] ACT_FMT = 2'd0;
    localparam logic [1:0] ACT_STR = 2'd1;
    localparam logic [1:0] ACT_END = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    localparam logic [2:0] NULL_LEN = 3'd6;

    typedef enum logic [2:0] {
        K_NONE,
        K_CHAR,
        K_NULL,
        K_NUM,
        K_REPORT
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DIGIT = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic dig_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic  in_valid;
        t_kind in_kind;
        logic  dig_last;
        logic  out_free;
        logic  emit_last;
    } t_sts;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        unique case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h61;
            4'hB: c = 8'h62;
            4'hC: c = 8'h63;
            4'hD: c = 8'h64;
            4'hE: c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] null_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0: c = 8'h28;
            3'd1: c = 8'h6E;
            3'd2: c = 8'h75;
            3'd3: c = 8'h6C;
            3'd4: c = 8'h6C;
            default: c = 8'h29;
        endcase
        return c;
    endfunction

endpackage

/* design/psf_if.sv */
// Valid/ready channel interfaces for format input items and result bytes.
interface psf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_in;
    logic [31:0] arg_value;
    logic       arg_is_null;

    modport source (output valid, output action, output char_in, output arg_value,
                    output arg_is_null, input ready);
    modport sink (input valid, input action, input char_in, input arg_value,
                  input arg_is_null, output ready);
endinterface

interface psf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic [30:0] running_count;
    logic        format_done;

    modport source (output valid, output out_byte, output last_of_run,
                    output running_count, output format_done, input ready);
    modport sink (input valid, input out_byte, input last_of_run,
                  input running_count, input format_done, output ready);
endinterface

/* design/psf_ctrl.sv */
// Controller state machine: accept, digit generation and byte emission.
module psf_ctrl
    import psf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.dig_step = 1'b0;
        o_cmd.emit     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    unique case (i_sts.in_kind)
                        K_NUM:                    n_state = ST_DIGIT;
                        K_CHAR, K_NULL, K_REPORT: n_state = ST_EMIT;
                        default:                  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_DIGIT: begin
                o_cmd.dig_step = 1'b1;
                if (i_sts.dig_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free && i_sts.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/psf_dp.sv */
// Datapath: item decode, digit generation, emit sequencing, byte count, output register.
module psf_dp
    import psf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    psf_in_if.sink    i_fmt,
    psf_out_if.source o_res,
    input  t_cmd      i_cmd,
    output t_sts      o_sts
);

    logic                 r_pending, n_pending;
    logic [CNT_W-1:0]     r_total, n_total;
    t_kind                r_kind, n_kind;
    logic [7:0]           r_char, n_char;
    logic [31:0]          r_val, n_val;
    logic                 r_hex, n_hex;
    logic                 r_neg, n_neg;
    logic [3:0]           r_dig [NUM_DIGITS];
    logic [3:0]           n_dig [NUM_DIGITS];
    logic [DIG_IDX_W-1:0] r_ndig, n_ndig;
    logic [3:0]           r_pos, n_pos;

    logic                 r_ov, n_ov;
    logic [7:0]           r_obyte, n_obyte;
    logic                 r_olast, n_olast;
    logic [CNT_W-1:0]     r_ocnt, n_ocnt;
    logic                 r_odone, n_odone;

    logic                 accept;
    t_kind                in_kind;
    logic                 in_pending;
    logic                 in_neg;
    logic [63:0]          prod;
    logic [31:0]          quot;
    logic [3:0]           digit;
    logic [3:0]           ten_q_lo;
    logic [3:0]           num_last;
    logic [DIG_IDX_W-1:0] rd_idx;
    logic [7:0]           emit_byte;
    logic                 emit_last;
    logic [CNT_W-1:0]     total_inc;

    assign accept = i_fmt.valid && i_cmd.in_ready;

    // Decode the offered item against the pending flag.
    always_comb begin
        in_kind    = K_NONE;
        in_pending = r_pending;
        unique case (i_fmt.action)
            ACT_FMT: begin
                if (!r_pending) begin
                    if (i_fmt.char_in == CH_PERCENT) begin
                        in_pending = 1'b1;
                    end else begin
                        in_kind = K_CHAR;
                    end
                end else begin
                    in_pending = 1'b0;
                    if (i_fmt.char_in == CH_S && i_fmt.arg_is_null) begin
                        in_kind = K_NULL;
                    end else if (i_fmt.char_in == CH_D || i_fmt.char_in == CH_X) begin
                        in_kind = K_NUM;
                    end
                end
            end
            ACT_STR: in_kind = K_CHAR;
            ACT_END: begin
                in_kind    = K_REPORT;
                in_pending = 1'b0;
            end
            default: in_kind = K_NONE;
        endcase
    end

    assign in_neg = (i_fmt.char_in == CH_D) && i_fmt.arg_value[31];

    // One digit per step: divide by ten through the reciprocal, or take a nibble.
    assign prod     = {32'd0, r_val} * {32'd0, RECIP_10};
    assign ten_q_lo = {prod[35], 3'b000} + {prod[37:35], 1'b0};
    always_comb begin
        if (r_hex) begin
            quot  = {4'd0, r_val[31:4]};
            digit = r_val[3:0];
        end else begin
            quot  = {3'd0, prod[63:35]};
            digit = r_val[3:0] - ten_q_lo;
        end
    end

    // Digits sit least significant first; read them back from the top.
    assign num_last = r_ndig - 4'd1 + {3'd0, r_neg};
    assign rd_idx   = DIG_IDX_W'(r_ndig - 4'd1 - (r_pos - {3'd0, r_neg}));

    always_comb begin
        emit_byte = 8'd0;
        emit_last = 1'b1;
        unique case (r_kind)
            K_CHAR: emit_byte = r_char;
            K_NULL: begin
                emit_byte = null_char(r_pos[2:0]);
                emit_last = (r_pos[2:0] == NULL_LEN - 3'd1);
            end
            K_NUM: begin
                if (r_neg && r_pos == 4'd0) begin
                    emit_byte = CH_MINUS;
                end else begin
                    emit_byte = hex_char(r_dig[rd_idx]);
                end
                emit_last = (r_pos == num_last);
            end
            default: begin
                emit_byte = 8'd0;
                emit_last = 1'b1;
            end
        endcase
    end

    assign total_inc = (r_total == COUNT_MAX) ? r_total : r_total + CNT_W'(1);

    always_comb begin
        n_pending = r_pending;
        n_total   = r_total;
        n_kind    = r_kind;
        n_char    = r_char;
        n_val     = r_val;
        n_hex     = r_hex;
        n_neg     = r_neg;
        n_dig     = r_dig;
        n_ndig    = r_ndig;
        n_pos     = r_pos;
        n_ov      = r_ov && !o_res.ready;
        n_obyte   = r_obyte;
        n_olast   = r_olast;
        n_ocnt    = r_ocnt;
        n_odone   = r_odone;

        if (accept) begin
            n_pending = in_pending;
            n_kind    = in_kind;
            n_char    = i_fmt.char_in;
            n_hex     = (i_fmt.char_in == CH_X);
            n_neg     = in_neg;
            n_val     = in_neg ? (32'd0 - i_fmt.arg_value) : i_fmt.arg_value;
            n_ndig    = '0;
            n_pos     = '0;
        end

        if (i_cmd.dig_step) begin
            n_dig[r_ndig] = digit;
            n_ndig = r_ndig + 1'b1;
            n_val  = quot;
        end

        if (i_cmd.emit) begin
            n_ov    = 1'b1;
            n_obyte = emit_byte;
            n_olast = emit_last;
            n_pos   = r_pos + 4'd1;
            if (r_kind == K_REPORT) begin
                n_ocnt  = r_total;
                n_odone = 1'b1;
                n_total = '0;
            end else begin
                n_ocnt  = total_inc;
                n_odone = 1'b0;
                n_total = total_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_total   <= '0;
            r_kind    <= K_NONE;
            r_ndig    <= '0;
            r_pos     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_total   <= n_total;
            r_kind    <= n_kind;
            r_ndig    <= n_ndig;
            r_pos     <= n_pos;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_val   <= n_val;
        r_hex   <= n_hex;
        r_neg   <= n_neg;
        r_dig   <= n_dig;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_ocnt  <= n_ocnt;
        r_odone <= n_odone;
    end

    assign i_fmt.ready         = i_cmd.in_ready;
    assign o_res.valid         = r_ov;
    assign o_res.out_byte      = r_obyte;
    assign o_res.last_of_run   = r_olast;
    assign o_res.running_count = r_ocnt;
    assign o_res.format_done   = r_odone;

    assign o_sts.in_valid  = i_fmt.valid;
    assign o_sts.in_kind   = in_kind;
    assign o_sts.dig_last  = (quot == 32'd0);
    assign o_sts.out_free  = !r_ov || o_res.ready;
    assign o_sts.emit_last = emit_last;

endmodule

/* design/printf_sdx_formatter.sv */
// Channel       | Dir | Payload
// i_fmt         | in  | action[1:0], char_in[7:0], arg_value[31:0], arg_is_null
// o_res         | out | out_byte[7:0], last_of_run, running_count[30:0], format_done
//
// A '%' or an item with nothing to emit is taken in ST_IDLE alone; a plain character, string byte or
// end item also passes through ST_EMIT. A %d or %x first runs the digit loop in ST_DIGIT, one
// reciprocal multiply or nibble shift per digit, then emits its bytes incl. sign in ST_EMIT.
// Reset is synchronous and clears the pending flag, byte count and control state.
// A stalled o_res holds emission; i_fmt is taken only between items.
// Top level of the printf %s/%d/%x formatter.
module printf_sdx_formatter
    import psf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    psf_in_if.sink    i_fmt,
    psf_out_if.source o_res
);

    t_cmd cmd;
    t_sts sts;

    psf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    psf_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fmt   (i_fmt),
        .o_res   (o_res),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

/* design/psf_checker.sv */
// Port-level checker for the printf formatter, bound to the top level.
module psf_checker
    import psf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_action,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic        i_out_last,
    input logic [30:0] i_out_count,
    input logic        i_out_done
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_count) && $stable(i_out_done) && $stable(i_out_last))
        else $error("result changed while stalled");

    // A count report is a single, zero-byte result.
    a_report_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_done |-> i_out_last && i_out_byte == 8'd0)
        else $error("malformed count report");

    // An emitted byte always counts itself.
    a_byte_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_done |-> i_out_count != '0)
        else $error("byte transfer with zero count");

    // String bytes and end items always produce output, so input closes.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_STR || i_in_action == ACT_END)
            |=> !i_in_ready)
        else $error("input taken while emitting");

endmodule

bind printf_sdx_formatter psf_checker u_psf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_fmt.valid),
    .i_in_ready  (i_fmt.ready),
    .i_in_action (i_fmt.action),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_byte  (o_res.out_byte),
    .i_out_last  (o_res.last_of_run),
    .i_out_count (o_res.running_count),
    .i_out_done  (o_res.format_done)
);
